// ===== rtl/jlbe_pkg.sv =====
// Package for the J1-J2 lattice bond energy scanner: lattice geometry, field widths,
// controller codes and the command and status structs. It depends on nothing else.
package jlbe_pkg;

  localparam int LATTICE_SIDE = 10;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ROW_W        = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
  localparam int SITE_W       = $clog2(SITE_COUNT);

  localparam int SITE_FIELD_W  = 7;
  localparam int FLAGS_W       = 4;
  localparam int COUPLING_W    = 16;
  localparam int SITE_ENERGY_W = 18;
  localparam int TOTAL_W       = 24;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  localparam logic [COUPLING_W-1:0] COUPLING_RESET = 16'd2048;
  localparam logic signed [SITE_ENERGY_W-1:0] ONE_Q12 = 18'sd4096;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 24'sh7FFFFF;
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 24'sh800000;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LATTICE_SIDE - 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD_B = 6'b000010,
    ST_RD_C = 6'b000100,
    ST_CAP  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_TOT  = 6'b100000
  } jlbe_state_t;

  typedef enum logic [1:0] {
    RD_SEL_NEAR = 2'd0,
    RD_SEL_DIAG = 2'd1,
    RD_SEL_LEFT = 2'd2
  } jlbe_rd_sel_t;

  typedef struct packed {
    logic         spin_wr;
    jlbe_rd_sel_t rd_sel;
    logic         cap_a;
    logic         cap_b;
    logic         cap_c;
    logic         sum_en;
    logic         commit;
  } jlbe_cmd_t;

  typedef struct packed {
    logic out_free;
  } jlbe_status_t;

  function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] x);
    return (x == LAST_ROW) ? '0 : ROW_W'(x + 1'b1);
  endfunction

  function automatic logic [ROW_W-1:0] wrap_dec(input logic [ROW_W-1:0] x);
    return (x == '0) ? LAST_ROW : ROW_W'(x - 1'b1);
  endfunction

  function automatic logic [SITE_W-1:0] site_of(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] c);
    return SITE_W'(SITE_W'(r) * SITE_W'(LATTICE_SIDE) + SITE_W'(c));
  endfunction

  function automatic logic [SITE_FIELD_W-1:0] site_field(input logic [SITE_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SITE_FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/jlbe_ctrl.sv =====
// Controller state machine of the lattice bond energy scanner.
// Depends on jlbe_pkg; drives the datapath only through command and status structs.
module jlbe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_opcode,
  output logic                  in_ready,
  input  jlbe_pkg::jlbe_status_t status,
  output jlbe_pkg::jlbe_cmd_t    cmd
);
  import jlbe_pkg::*;

  jlbe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SEL_NEAR;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_SCAN) begin
            state_next = ST_RD_B;
          end else begin
            cmd.spin_wr = 1'b1;
          end
        end
      end
      ST_RD_B: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = RD_SEL_DIAG;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_sel = RD_SEL_LEFT;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_c  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_TOT;
      end
      ST_TOT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/jlbe_datapath.sv =====
// Datapath of the lattice bond energy scanner: spin memory, scan counters,
// bond energy adder, saturating total and the output register. Depends on jlbe_pkg.
module jlbe_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  jlbe_pkg::jlbe_cmd_t                    cmd,
  output jlbe_pkg::jlbe_status_t                 status,
  input  logic                                   cfg_wr_en,
  input  logic [jlbe_pkg::COUPLING_W-1:0]        cfg_wr_data,
  input  logic [jlbe_pkg::SITE_FIELD_W-1:0]      site_index,
  input  logic                                   spin_up,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [jlbe_pkg::OUT_TDATA_W-1:0]       out_data,
  output logic                                   out_last
);
  import jlbe_pkg::*;

  logic spin_mem [SITE_COUNT];

  logic [COUPLING_W-1:0] coupling_j2;
  logic [ROW_W-1:0] row, col;
  logic signed [TOTAL_W-1:0] total;
  logic rd0, rd1;
  logic spin_self, spin_down, spin_right, spin_dr, spin_dl;
  logic [FLAGS_W-1:0] flags;
  logic signed [SITE_ENERGY_W-1:0] site_e;

  logic [ROW_W-1:0] row_dn, col_rt, col_lt;
  logic [SITE_W-1:0] pos, nb_down, nb_right, nb_dr, nb_dl;
  logic [SITE_W-1:0] addr0, addr1;
  logic load_ok;
  logic is_last;
  logic [FLAGS_W-1:0] flags_next;
  logic signed [SITE_ENERGY_W-1:0] j2_ext, site_e_next;
  logic signed [TOTAL_W:0] total_sum;
  logic signed [TOTAL_W-1:0] total_sat;

  assign row_dn   = wrap_inc(row);
  assign col_rt   = wrap_inc(col);
  assign col_lt   = wrap_dec(col);
  assign pos      = site_of(row, col);
  assign nb_down  = site_of(row_dn, col);
  assign nb_right = site_of(row, col_rt);
  assign nb_dr    = site_of(row_dn, col_rt);
  assign nb_dl    = site_of(row_dn, col_lt);
  assign is_last  = (row == LAST_ROW) && (col == LAST_ROW);
  assign load_ok  = 32'(site_index) < SITE_COUNT;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SEL_NEAR: begin
        addr0 = pos;
        addr1 = nb_down;
      end
      RD_SEL_DIAG: begin
        addr0 = nb_right;
        addr1 = nb_dr;
      end
      RD_SEL_LEFT: begin
        addr0 = nb_dl;
        addr1 = nb_dl;
      end
      default: begin
        addr0 = pos;
        addr1 = nb_down;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.spin_wr && load_ok) begin
      spin_mem[SITE_W'(site_index)] <= spin_up;
    end
    rd0 <= spin_mem[addr0];
    rd1 <= spin_mem[addr1];
  end

  assign flags_next = {spin_self ^ spin_dl, spin_self ^ spin_dr,
                       spin_self ^ spin_right, spin_self ^ spin_down};
  assign j2_ext     = SITE_ENERGY_W'(signed'(coupling_j2));
  assign site_e_next = (flags_next[0] ? -ONE_Q12 : ONE_Q12)
                     + (flags_next[1] ? -ONE_Q12 : ONE_Q12)
                     + (flags_next[2] ? -j2_ext : j2_ext)
                     + (flags_next[3] ? -j2_ext : j2_ext);

  assign total_sum = {total[TOTAL_W-1], total}
                   + {{(TOTAL_W + 1 - SITE_ENERGY_W){site_e[SITE_ENERGY_W-1]}}, site_e};

  always_comb begin
    if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1]) begin
      total_sat = total_sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_sat = total_sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      spin_self <= rd0;
      spin_down <= rd1;
    end
    if (cmd.cap_b) begin
      spin_right <= rd0;
      spin_dr    <= rd1;
    end
    if (cmd.cap_c) begin
      spin_dl <= rd0;
    end
    if (cmd.sum_en) begin
      flags  <= flags_next;
      site_e <= site_e_next;
    end
    if (cmd.commit) begin
      out_data <= {7'd0, total_sat, site_e, flags,
                   site_field(nb_dl), site_field(nb_dr), site_field(nb_right),
                   site_field(nb_down), site_field(pos)};
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_j2 <= COUPLING_RESET;
      row         <= '0;
      col         <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        coupling_j2 <= cfg_wr_data;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (is_last) begin
          row   <= '0;
          col   <= '0;
          total <= '0;
        end else begin
          total <= total_sat;
          col   <= col_rt;
          if (col == LAST_ROW) begin
            row <= row_dn;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/j1_j2_lattice_bond_energy.sv =====
// Top level of the J1-J2 lattice bond energy scanner: joins the controller and datapath.
// Depends on jlbe_pkg, jlbe_ctrl and jlbe_datapath.
//
//   channel   direction  fields
//   s_axis    in         tuser: opcode; tdata: site_index, spin_up
//   m_axis    out        tdata: sites, anti_flags, energies; tlast: last_site
//   cfg       in         cfg_wr_data: coupling_j2
//
// A load writes its spin in the idle state, where the next input can be taken. A scan
// takes no new input from acceptance through three read steps for the five spins through
// the two read ports, a capture step, the bond sum and the total, which registers the
// result. A scan waits in its last step while a previous result is still held in
// the output register. Reset clears the scan position and the total and restores the
// default coupling; the spin memory is not cleared.
module j1_j2_lattice_bond_energy (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [jlbe_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // site_index, spin_up
  input  logic                                  s_axis_tuser,  // opcode
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // source_site, down_site, right_site, down_right_site, down_left_site,
  // anti_flags, site_energy, total_energy, zero fill
  output logic [jlbe_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_wr_en,
  input  logic [jlbe_pkg::COUPLING_W-1:0]       cfg_wr_data
);
  import jlbe_pkg::*;

  jlbe_cmd_t    cmd;
  jlbe_status_t status;

  jlbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  jlbe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .site_index  (s_axis_tdata[SITE_FIELD_W-1:0]),
    .spin_up     (s_axis_tdata[SITE_FIELD_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

// ===== rtl/jlbe_checker.sv =====
// Port-level checker for the lattice bond energy scanner, bound to the top level.
// Depends on jlbe_pkg and j1_j2_lattice_bond_energy.
module jlbe_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jlbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import jlbe_pkg::*;

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    s_xfer && s_axis_tuser == OP_LOAD && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("a load transaction produced a result");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    s_xfer && s_axis_tuser == OP_SCAN |=> !s_axis_tready)
    else $error("input taken while a scan is in progress");

endmodule

bind j1_j2_lattice_bond_energy jlbe_checker u_jlbe_checker (.*);
